FILE: design/psv_pkg.sv
// Shared types, constants and byte-class functions of the path string validator.
`timescale 1ns / 1ps

package psv_pkg;

   localparam int LENGTH_WIDTH_DEF = 16;
   localparam int CFG_LEN_WIDTH    = 16;
   localparam int OUT_LEN_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 16;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_LENGTH     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_STRICT_MODE    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ALLOW_RELATIVE = 2'd2;

   localparam logic [CFG_LEN_WIDTH-1:0] MAX_LENGTH_RST = 16'd4096;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_EMPTY     = 3'd1;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
   localparam logic [2:0] ERR_NULL      = 3'd3;
   localparam logic [2:0] ERR_TRAVERSAL = 3'd4;
   localparam logic [2:0] ERR_CONTROL   = 3'd5;
   localparam logic [2:0] ERR_SHELL     = 3'd6;
   localparam logic [2:0] ERR_UTF8      = 3'd7;

   localparam int FLT_NULL  = 0;
   localparam int FLT_TRAV  = 1;
   localparam int FLT_CTRL  = 2;
   localparam int FLT_SHELL = 3;
   localparam int FLT_UTF8  = 4;

   localparam logic [1:0] LIM_NONE = 2'd0;
   localparam logic [1:0] LIM_A0   = 2'd1;
   localparam logic [1:0] LIM_8F   = 2'd2;
   localparam logic [1:0] LIM_90   = 2'd3;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       has_byte;
      logic       last;
      logic       is_ws;
      logic       ws_ctrl;
      logic       ws_nl;
      logic       is_ctrl;
      logic       is_shell;
      logic       is_null;
      logic       is_slash;
   } item_type;

   typedef struct packed {
      logic [CFG_LEN_WIDTH-1:0] max_length;
      logic                     strict_mode;
      logic                     allow_relative;
   } cfg_type;

   // index 0 is the newest byte
   typedef logic [4:0][7:0] history_type;

   function automatic logic is_shell_char(logic [7:0] c);
      logic hit;
      case (c) inside
         8'h7C, 8'h3B, 8'h26, 8'h24, 8'h60, 8'h22, 8'h27, 8'h3C, 8'h3E, 8'h28, 8'h29,
         8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h21, 8'h23, 8'h2A, 8'h3F, 8'h5C, 8'h7E,
         CH_LF, CH_CR: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // history followed by c ends in "..", "%2e%2e", "%252e" or "%c0%ae" (either case)
   function automatic logic is_traversal(history_type h, logic [7:0] c);
      logic dots;
      logic enc_lo;
      logic enc_up;
      logic dbl_lo;
      logic dbl_up;
      logic ovl_lo;
      logic ovl_up;
      dots   = (c == 8'h2E) && (h[0] == 8'h2E);
      enc_lo = (c == 8'h65) && (h[0] == 8'h32) && (h[1] == 8'h25) && (h[2] == 8'h65)
               && (h[3] == 8'h32) && (h[4] == 8'h25);
      enc_up = (c == 8'h45) && (h[0] == 8'h32) && (h[1] == 8'h25) && (h[2] == 8'h45)
               && (h[3] == 8'h32) && (h[4] == 8'h25);
      dbl_lo = (c == 8'h65) && (h[0] == 8'h32) && (h[1] == 8'h35) && (h[2] == 8'h32)
               && (h[3] == 8'h25);
      dbl_up = (c == 8'h45) && (h[0] == 8'h32) && (h[1] == 8'h35) && (h[2] == 8'h32)
               && (h[3] == 8'h25);
      ovl_lo = (c == 8'h65) && (h[0] == 8'h61) && (h[1] == 8'h25) && (h[2] == 8'h30)
               && (h[3] == 8'h63) && (h[4] == 8'h25);
      ovl_up = (c == 8'h45) && (h[0] == 8'h41) && (h[1] == 8'h25) && (h[2] == 8'h30)
               && (h[3] == 8'h43) && (h[4] == 8'h25);
      return dots | enc_lo | enc_up | dbl_lo | dbl_up | ovl_lo | ovl_up;
   endfunction

endpackage

FILE: design/path_string_validator.sv
// Top level of the path string validator: config registers, front, queue and back.
`timescale 1ns / 1ps

// Usage:
//   req_ channel: one byte of a path per transaction (req_byte_value, req_has_byte,
//   req_last). A transaction with req_last high closes the string; exactly one
//   verdict transaction follows on the rsp_ channel, none for other bytes.
//   rsp_ channel: rsp_valid_res, rsp_error_code, rsp_trimmed_length.
//   csr_ channel: csr_index selects max_length (0), strict_mode (1) or
//   allow_relative (2); other indexes are ignored. csr_ready is always high.
//   Write registers only while no string is in flight.
// Timing:
//   One byte per cycle while req_stall is low. rsp_valid is registered: the closing
//   byte passes through the queue and sets the verdict register when popped; the
//   per-byte state update in the back end is a loop through its state registers
//   and sets the rate. A four-entry queue decouples the classifier from the checker,
//   so bytes keep flowing while a verdict waits under rsp_stall until the next
//   closing byte reaches the head; req_stall rises only when the queue is full.
// Reset: clears the queue, the running path state and any pending verdict, and
//   loads max_length 4096, strict_mode 0, allow_relative 1.
module path_string_validator #(
   parameter int LENGTH_WIDTH = psv_pkg::LENGTH_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_byte_value,
   input  logic                                   req_has_byte,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid_res,
   output logic [2:0]                             rsp_error_code,
   output logic [psv_pkg::OUT_LEN_WIDTH-1:0]      rsp_trimmed_length,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [psv_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [psv_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);
   import psv_pkg::*;

   cfg_type  cfg_ff;
   item_type front_item;
   item_type head_item;
   logic     q_full;
   logic     head_valid;
   logic     pop;
   logic     push;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_length     <= MAX_LENGTH_RST;
         cfg_ff.strict_mode    <= 1'b0;
         cfg_ff.allow_relative <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MAX_LENGTH:     cfg_ff.max_length     <= csr_data[CFG_LEN_WIDTH-1:0];
            REG_STRICT_MODE:    cfg_ff.strict_mode    <= csr_data[0];
            REG_ALLOW_RELATIVE: cfg_ff.allow_relative <= csr_data[0];
            default: ;
         endcase
      end
   end

   psv_front u_front (
      .byte_value (req_byte_value),
      .has_byte   (req_has_byte),
      .last       (req_last),
      .item       (front_item)
   );

   psv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   psv_back #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .head_valid         (head_valid),
      .head_item          (head_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_valid_res      (rsp_valid_res),
      .rsp_error_code     (rsp_error_code),
      .rsp_trimmed_length (rsp_trimmed_length)
   );

   a_verdict_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pop && head_item.last))
      else $error("verdict raised without a closing byte");

   a_pass_means_no_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |-> (rsp_error_code == ERR_NONE))
      else $error("passing verdict carries an error code");

   a_empty_zero_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error_code == ERR_EMPTY)) |-> (rsp_trimmed_length == '0))
      else $error("empty verdict with nonzero length");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      (q_full && !pop) |=> q_full)
      else $error("queue lost an entry without a pop");

endmodule

FILE: design/psv_front.sv
// Front end: classifies each incoming byte for the checker.
`timescale 1ns / 1ps

module psv_front (
   input  logic [7:0]        byte_value,
   input  logic              has_byte,
   input  logic              last,
   output psv_pkg::item_type item
);
   import psv_pkg::*;

   logic ws;

   assign ws = (byte_value == CH_SPACE) || ((byte_value >= CH_TAB) && (byte_value <= CH_CR));

   always_comb begin
      item.byte_value = byte_value;
      item.has_byte   = has_byte;
      item.last       = last;
      item.is_ws      = ws;
      item.ws_ctrl    = ws && (byte_value != CH_SPACE) && (byte_value != CH_TAB);
      item.ws_nl      = (byte_value == CH_LF) || (byte_value == CH_CR);
      item.is_ctrl    = ((byte_value < CH_SPACE) && (byte_value != CH_TAB))
                        || (byte_value == CH_DEL);
      item.is_shell   = is_shell_char(byte_value);
      item.is_null    = (byte_value == CH_NUL);
      item.is_slash   = (byte_value == CH_SLASH);
   end

endmodule

FILE: design/psv_queue.sv
// Short flop-based queue between the classifier and the checker.
`timescale 1ns / 1ps

module psv_queue #(
   parameter int DEPTH = psv_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  psv_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output psv_pkg::item_type head_item
);
   import psv_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: design/psv_back.sv
// Back end: running path state, pattern and UTF-8 checks, verdict register.
`timescale 1ns / 1ps

module psv_back #(
   parameter int LENGTH_WIDTH = psv_pkg::LENGTH_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  psv_pkg::cfg_type                      cfg,
   input  logic                                  head_valid,
   input  psv_pkg::item_type                     head_item,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid_res,
   output logic [2:0]                            rsp_error_code,
   output logic [psv_pkg::OUT_LEN_WIDTH-1:0]     rsp_trimmed_length
);
   import psv_pkg::*;

   localparam int LW = LENGTH_WIDTH;
   localparam int CW = (LW > OUT_LEN_WIDTH) ? LW : OUT_LEN_WIDTH;
   localparam logic [LW-1:0] LEN_MAX = '1;
   localparam logic [CW-1:0] OUT_MAX = CW'({OUT_LEN_WIDTH{1'b1}});

   logic              seen_ff, seen_in;
   logic              slash_ff, slash_in;
   logic [LW-1:0]     kept_ff, kept_in;
   logic [LW-1:0]     pend_ff, pend_in;
   logic [1:0]        pflags_ff, pflags_in;
   logic [4:0]        fault_ff, fault_in;
   history_type       hist_ff, hist_in;
   logic [1:0]        rem_ff, rem_in;
   logic [1:0]        lim_ff, lim_in;

   history_type       hist_eff;
   logic [1:0]        rem_eff;
   logic [1:0]        lim_eff;
   logic [LW+1:0]     kept_sum;
   logic [7:0]        c;
   logic              bad;
   logic [CW-1:0]     kept_x;
   logic [2:0]        code;
   logic              out_free;

   logic              rsp_valid_ff;
   logic              res_ok_ff;
   logic [2:0]        res_code_ff;
   logic [OUT_LEN_WIDTH-1:0] res_len_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head_valid && (!head_item.last || out_free);
   assign c        = head_item.byte_value;

   always_comb begin
      seen_in   = seen_ff;
      slash_in  = slash_ff;
      kept_in   = kept_ff;
      pend_in   = pend_ff;
      pflags_in = pflags_ff;
      fault_in  = fault_ff;
      hist_in   = hist_ff;
      rem_in    = rem_ff;
      lim_in    = lim_ff;
      hist_eff  = hist_ff;
      rem_eff   = rem_ff;
      lim_eff   = lim_ff;
      kept_sum  = {2'b00, kept_ff} + {2'b00, pend_ff} + (LW+2)'(1);
      bad       = 1'b0;
      if (head_item.has_byte) begin
         if (head_item.is_ws) begin
            if (seen_ff) begin
               pend_in   = (pend_ff == LEN_MAX) ? LEN_MAX : pend_ff + 1'b1;
               pflags_in = pflags_ff | {head_item.ws_nl, head_item.ws_ctrl};
            end
         end else begin
            if (!seen_ff) begin
               seen_in  = 1'b1;
               slash_in = head_item.is_slash;
            end
            // pending whitespace is committed as a single space in the history
            if (pend_ff != '0) begin
               fault_in[FLT_CTRL]  = fault_in[FLT_CTRL] | pflags_ff[0];
               fault_in[FLT_SHELL] = fault_in[FLT_SHELL] | pflags_ff[1];
               if (rem_ff != 2'd0) begin
                  fault_in[FLT_UTF8] = 1'b1;
                  rem_eff = 2'd0;
                  lim_eff = LIM_NONE;
               end
               hist_eff  = {hist_ff[3:0], CH_SPACE};
               pend_in   = '0;
               pflags_in = 2'b00;
            end
            kept_in = (kept_sum > {2'b00, LEN_MAX}) ? LEN_MAX : kept_sum[LW-1:0];
            fault_in[FLT_NULL]  = fault_in[FLT_NULL] | head_item.is_null;
            fault_in[FLT_TRAV]  = fault_in[FLT_TRAV] | is_traversal(hist_eff, c);
            fault_in[FLT_CTRL]  = fault_in[FLT_CTRL] | head_item.is_ctrl;
            fault_in[FLT_SHELL] = fault_in[FLT_SHELL] | head_item.is_shell;
            rem_in = rem_eff;
            lim_in = lim_eff;
            if (rem_eff != 2'd0) begin
               bad = (c[7:6] != 2'b10)
                     || ((lim_eff == LIM_A0) && (c < 8'hA0))
                     || ((lim_eff == LIM_8F) && (c > 8'h8F))
                     || ((lim_eff == LIM_90) && (c < 8'h90));
               lim_in = LIM_NONE;
               if (bad) begin
                  fault_in[FLT_UTF8] = 1'b1;
                  rem_in = 2'd0;
               end else begin
                  rem_in = rem_eff - 1'b1;
               end
            end else if (c[7] == 1'b0) begin
               rem_in = 2'd0;
            end else if (c[7:5] == 3'b110) begin
               if (c < 8'hC2) begin
                  fault_in[FLT_UTF8] = 1'b1;
               end else begin
                  rem_in = 2'd1;
               end
            end else if (c[7:4] == 4'b1110) begin
               rem_in = 2'd2;
               lim_in = (c == 8'hE0) ? LIM_A0 : LIM_NONE;
            end else if ((c[7:3] == 5'b11110) && (c <= 8'hF4)) begin
               rem_in = 2'd3;
               lim_in = (c == 8'hF0) ? LIM_90 : ((c == 8'hF4) ? LIM_8F : LIM_NONE);
            end else begin
               fault_in[FLT_UTF8] = 1'b1;
            end
            hist_in = {hist_eff[3:0], c};
         end
      end
   end

   assign kept_x = CW'(kept_in);

   always_comb begin
      if (!seen_in) begin
         code = ERR_EMPTY;
      end else if (kept_x > CW'(cfg.max_length)) begin
         code = ERR_TOO_LONG;
      end else if (fault_in[FLT_NULL]) begin
         code = ERR_NULL;
      end else if (fault_in[FLT_TRAV]) begin
         code = ERR_TRAVERSAL;
      end else if (fault_in[FLT_CTRL]) begin
         code = ERR_CONTROL;
      end else if (cfg.strict_mode && fault_in[FLT_SHELL]) begin
         code = ERR_SHELL;
      end else if (fault_in[FLT_UTF8] || (rem_in != 2'd0)) begin
         code = ERR_UTF8;
      end else if (!cfg.allow_relative && !slash_in) begin
         code = ERR_TRAVERSAL;
      end else begin
         code = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (pop && head_item.last)) begin
         seen_ff   <= 1'b0;
         slash_ff  <= 1'b0;
         kept_ff   <= '0;
         pend_ff   <= '0;
         pflags_ff <= 2'b00;
         fault_ff  <= 5'b0;
         hist_ff   <= '0;
         rem_ff    <= 2'd0;
         lim_ff    <= LIM_NONE;
      end else if (pop) begin
         seen_ff   <= seen_in;
         slash_ff  <= slash_in;
         kept_ff   <= kept_in;
         pend_ff   <= pend_in;
         pflags_ff <= pflags_in;
         fault_ff  <= fault_in;
         hist_ff   <= hist_in;
         rem_ff    <= rem_in;
         lim_ff    <= lim_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && head_item.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_item.last) begin
         res_ok_ff   <= (code == ERR_NONE);
         res_code_ff <= code;
         if (!seen_in) begin
            res_len_ff <= '0;
         end else if (kept_x > OUT_MAX) begin
            res_len_ff <= {OUT_LEN_WIDTH{1'b1}};
         end else begin
            res_len_ff <= kept_x[OUT_LEN_WIDTH-1:0];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_valid_res      = res_ok_ff;
   assign rsp_error_code     = res_code_ff;
   assign rsp_trimmed_length = res_len_ff;

endmodule

FILE: bench/tb_path_string_validator.sv
// Self-checking testbench for path_string_validator: random and directed paths, predicted verdicts.
`timescale 1ns / 1ps

module tb_path_string_validator;
   import psv_pkg::*;

   localparam int unsigned LEN_SAT       = (1 << LENGTH_WIDTH_DEF) - 1;
   localparam int          LONG_HOLD     = 150;
   localparam int          SETTLE_CYCLES = 12;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       has_byte;
      logic       is_last;
   } path_item_type;

   typedef struct packed {
      logic                     ok;
      logic [2:0]               code;
      logic [OUT_LEN_WIDTH-1:0] len;
   } verdict_type;

   typedef struct packed {
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  value;
   } reg_write_type;

   typedef logic [7:0] byte_q_type [$];

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_byte_value = '0;
   logic                       req_has_byte   = 1'b0;
   logic                       req_last       = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic                       rsp_valid_res;
   logic [2:0]                 rsp_error_code;
   logic [OUT_LEN_WIDTH-1:0]   rsp_trimmed_length;
   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index      = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data       = '0;

   path_item_type byte_feed [$];
   verdict_type   pending_verdicts [$];
   reg_write_type reg_writes [$];

   int sender_idle_pct = 0;
   int rsp_idle_pct    = 0;
   int hold_requests   = 0;
   int holds_done      = 0;
   int hold_left       = 0;
   int stall_left      = 0;
   int feed_gap        = 0;
   int fail_count      = 0;

   // shadow configuration
   logic [CFG_LEN_WIDTH-1:0] cfg_max_len   = MAX_LENGTH_RST;
   logic                     cfg_strict    = 1'b0;
   logic                     cfg_allow_rel = 1'b1;

   // shadow path state
   logic        seen        = 1'b0;
   int unsigned kept        = 0;
   int unsigned pend_cnt    = 0;
   logic        pend_ctrl   = 1'b0;
   logic        pend_nl     = 1'b0;
   logic [4:0]  faults      = '0;
   logic [7:0]  hist [5]    = '{default: 8'h00};
   logic [1:0]  mb_left     = '0;
   logic [1:0]  mb_limit    = LIM_NONE;
   logic        slash_first = 1'b0;

   string trav_patterns [7] = '{"..", "%2e%2e", "%2E%2E", "%252e", "%252E", "%c0%ae", "%C0%AE"};
   logic [7:0] shell_meta [23] = '{8'h7C, 8'h3B, 8'h26, 8'h24, 8'h60, 8'h22, 8'h27, 8'h3C,
                                   8'h3E, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h21,
                                   8'h23, 8'h2A, 8'h3F, 8'h5C, 8'h7E, CH_LF, CH_CR};

   path_string_validator u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_value     (req_byte_value),
      .req_has_byte       (req_has_byte),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_valid_res      (rsp_valid_res),
      .rsp_error_code     (rsp_error_code),
      .rsp_trimmed_length (rsp_trimmed_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial forever #4 clock = ~clock;

   initial begin
      #(500us);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic ws_byte(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic int unsigned len_add(int unsigned a, int unsigned b);
      return (a + b > LEN_SAT) ? LEN_SAT : a + b;
   endfunction

   function automatic void shift_hist(logic [7:0] c);
      for (int i = 4; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = c;
   endfunction

   function automatic void utf8_track(logic [7:0] c);
      logic bad;
      if (mb_left != 0) begin
         bad = c[7:6] != 2'b10;
         if (mb_limit == LIM_A0 && c < 8'hA0) bad = 1'b1;
         if (mb_limit == LIM_8F && c > 8'h8F) bad = 1'b1;
         if (mb_limit == LIM_90 && c < 8'h90) bad = 1'b1;
         mb_limit = LIM_NONE;
         if (bad) begin
            faults[FLT_UTF8] = 1'b1;
            mb_left = '0;
         end else begin
            mb_left = mb_left - 2'd1;
         end
      end else if (c[7]) begin
         if (c[7:5] == 3'b110) begin
            if (c < 8'hC2) faults[FLT_UTF8] = 1'b1;
            else mb_left = 2'd1;
         end else if (c[7:4] == 4'b1110) begin
            mb_left  = 2'd2;
            mb_limit = (c == 8'hE0) ? LIM_A0 : LIM_NONE;
         end else if (c[7:3] == 5'b11110 && c <= 8'hF4) begin
            mb_left  = 2'd3;
            mb_limit = (c == 8'hF0) ? LIM_90 : (c == 8'hF4) ? LIM_8F : LIM_NONE;
         end else begin
            faults[FLT_UTF8] = 1'b1;
         end
      end
   endfunction

   function automatic void take_byte(logic [7:0] c);
      int   n;
      logic m;
      if (!seen) begin
         seen        = 1'b1;
         slash_first = (c == CH_SLASH);
      end
      // held whitespace is committed as a single space in the history
      if (pend_cnt != 0) begin
         kept = len_add(kept, pend_cnt);
         if (pend_ctrl) faults[FLT_CTRL] = 1'b1;
         if (pend_nl) faults[FLT_SHELL] = 1'b1;
         if (mb_left != 0) begin
            faults[FLT_UTF8] = 1'b1;
            mb_left  = '0;
            mb_limit = LIM_NONE;
         end
         shift_hist(CH_SPACE);
         pend_cnt  = 0;
         pend_ctrl = 1'b0;
         pend_nl   = 1'b0;
      end
      kept = len_add(kept, 1);
      if (c == CH_NUL) faults[FLT_NULL] = 1'b1;
      foreach (trav_patterns[p]) begin
         n = trav_patterns[p].len();
         m = (8'(trav_patterns[p][n-1]) == c);
         for (int i = 0; i < n - 1; i++)
            if (8'(trav_patterns[p][n-2-i]) != hist[i]) m = 1'b0;
         if (m) faults[FLT_TRAV] = 1'b1;
      end
      if ((c < CH_SPACE && c != CH_TAB) || c == CH_DEL) faults[FLT_CTRL] = 1'b1;
      foreach (shell_meta[k])
         if (shell_meta[k] == c) faults[FLT_SHELL] = 1'b1;
      utf8_track(c);
      shift_hist(c);
   endfunction

   function automatic void path_verdict_step(logic [7:0] c, logic has_byte, logic is_last);
      verdict_type v;
      logic [2:0] code;
      if (has_byte) begin
         if (ws_byte(c)) begin
            if (seen) begin
               pend_cnt = len_add(pend_cnt, 1);
               if (c != CH_SPACE && c != CH_TAB) pend_ctrl = 1'b1;
               if (c == CH_LF || c == CH_CR) pend_nl = 1'b1;
            end
         end else begin
            take_byte(c);
         end
      end
      if (!is_last) return;
      if (!seen) code = ERR_EMPTY;
      else if (kept > cfg_max_len) code = ERR_TOO_LONG;
      else if (faults[FLT_NULL]) code = ERR_NULL;
      else if (faults[FLT_TRAV]) code = ERR_TRAVERSAL;
      else if (faults[FLT_CTRL]) code = ERR_CONTROL;
      else if (cfg_strict && faults[FLT_SHELL]) code = ERR_SHELL;
      else if (faults[FLT_UTF8] || mb_left != 0) code = ERR_UTF8;
      else if (!cfg_allow_rel && !slash_first) code = ERR_TRAVERSAL;
      else code = ERR_NONE;
      v.ok   = (code == ERR_NONE);
      v.code = code;
      v.len  = seen ? OUT_LEN_WIDTH'(kept) : '0;
      pending_verdicts.push_back(v);
      seen        = 1'b0;
      kept        = 0;
      pend_cnt    = 0;
      pend_ctrl   = 1'b0;
      pend_nl     = 1'b0;
      faults      = '0;
      hist        = '{default: 8'h00};
      mb_left     = '0;
      mb_limit    = LIM_NONE;
      slash_first = 1'b0;
   endfunction

   always @(posedge clock) begin : byte_driver
      path_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         feed_gap  <= 0;
      end else begin
         if (req_valid && !req_stall)
            path_verdict_step(req_byte_value, req_has_byte, req_last);
         if (!req_valid || !req_stall) begin
            if (feed_gap != 0) begin
               feed_gap  <= feed_gap - 1;
               req_valid <= 1'b0;
            end else if (byte_feed.size() == 0) begin
               req_valid <= 1'b0;
            end else if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
               feed_gap  <= int'($urandom_range(0, 6));
               req_valid <= 1'b0;
            end else begin
               nxt = byte_feed.pop_front();
               req_byte_value <= nxt.byte_value;
               req_has_byte   <= nxt.has_byte;
               req_last       <= nxt.is_last;
               req_valid      <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_backpressure
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (holds_done != hold_requests) begin
         holds_done <= holds_done + 1;
         hold_left  <= LONG_HOLD - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
         stall_left <= int'($urandom_range(0, 6));
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : csr_driver
      reg_write_type w;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MAX_LENGTH:     cfg_max_len   = csr_data;
               REG_STRICT_MODE:    cfg_strict    = csr_data[0];
               REG_ALLOW_RELATIVE: cfg_allow_rel = csr_data[0];
               default: ;
            endcase
         end
         if (!csr_valid || csr_ready) begin
            if (reg_writes.size() != 0) begin
               w = reg_writes.pop_front();
               csr_index <= w.index;
               csr_data  <= w.value;
               csr_valid <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_fault(string what, verdict_type want);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t %s: expected ok=%0d code=%0d len=%0d, got ok=%0d code=%0d len=%0d",
                  $time, what, want.ok, want.code, want.len,
                  rsp_valid_res, rsp_error_code, rsp_trimmed_length);
   endtask

   always @(posedge clock) begin : verdict_monitor
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            report_fault("verdict with none pending", '0);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_valid_res !== want.ok || rsp_error_code !== want.code ||
                rsp_trimmed_length !== want.len)
               report_fault("verdict mismatch", want);
         end
      end
   end

   function automatic logic [7:0] pick_space();
      int unsigned r;
      r = $urandom_range(0, 7);
      return (r < 5) ? CH_TAB + 8'(r) : CH_SPACE;
   endfunction

   function automatic logic [7:0] cont_byte();
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   // queues one path; own_term closes it with a separate byte-less transaction
   function automatic int add_path(byte_q_type s, logic own_term);
      path_item_type it;
      int n;
      n = 0;
      foreach (s[i]) begin
         if ($urandom_range(0, 19) == 0) begin
            it = '{8'($urandom), 1'b0, 1'b0};
            byte_feed.push_back(it);
         end
         it = '{s[i], 1'b1, !own_term && i == s.size() - 1};
         byte_feed.push_back(it);
         n++;
      end
      if (own_term || s.size() == 0) begin
         it = '{8'($urandom), 1'b0, 1'b1};
         byte_feed.push_back(it);
         n++;
      end
      return n;
   endfunction

   function automatic byte_q_type text_bytes(string t);
      byte_q_type s;
      for (int i = 0; i < t.len(); i++) s.push_back(8'(t[i]));
      return s;
   endfunction

   function automatic byte_q_type random_path();
      byte_q_type s;
      string pat;
      int kind;
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) s.push_back(pick_space());
      if ($urandom_range(0, 5) != 0) s.push_back(CH_SLASH);
      repeat ($urandom_range(0, 5)) begin
         kind = int'($urandom_range(0, 99));
         if (kind < 50) begin
            repeat ($urandom_range(1, 4)) s.push_back(8'h61 + 8'($urandom_range(0, 25)));
            if ($urandom_range(0, 1) == 0) s.push_back(CH_SLASH);
         end else if (kind < 57) begin
            pat = trav_patterns[$urandom_range(0, 6)];
            for (int i = 0; i < pat.len(); i++) s.push_back(8'(pat[i]));
            // near miss
            if ($urandom_range(0, 2) == 0) s[s.size()-1] = 8'h78;
         end else if (kind < 61) begin
            s.push_back(8'h2E);
            s.push_back(CH_SLASH);
         end else if (kind < 69) begin
            case ($urandom_range(0, 5))
               0: s.push_back(8'($urandom_range(8'hC2, 8'hDF)));
               1: begin
                  s.push_back(8'hE0);
                  s.push_back(8'($urandom_range(8'hA0, 8'hBF)));
               end
               2: begin
                  s.push_back(8'($urandom_range(8'hE1, 8'hEF)));
                  s.push_back(cont_byte());
               end
               3: begin
                  s.push_back(8'hF0);
                  s.push_back(8'($urandom_range(8'h90, 8'hBF)));
                  s.push_back(cont_byte());
               end
               4: begin
                  s.push_back(8'($urandom_range(8'hF1, 8'hF3)));
                  s.push_back(cont_byte());
                  s.push_back(cont_byte());
               end
               default: begin
                  s.push_back(8'hF4);
                  s.push_back(8'($urandom_range(8'h80, 8'h8F)));
                  s.push_back(cont_byte());
               end
            endcase
            s.push_back(cont_byte());
         end else if (kind < 75) begin
            case ($urandom_range(0, 6))
               0: begin
                  s.push_back(8'($urandom_range(8'hC0, 8'hC1)));
                  s.push_back(cont_byte());
               end
               1: s.push_back(8'($urandom_range(8'hF5, 8'hFF)));
               2: s.push_back(cont_byte());
               3: begin
                  s.push_back(8'hE0);
                  s.push_back(8'($urandom_range(8'h80, 8'h9F)));
                  s.push_back(cont_byte());
               end
               4: begin
                  s.push_back(8'hF0);
                  s.push_back(8'($urandom_range(8'h80, 8'h8F)));
                  s.push_back(cont_byte());
                  s.push_back(cont_byte());
               end
               5: begin
                  s.push_back(8'hF4);
                  s.push_back(8'($urandom_range(8'h90, 8'hBF)));
                  s.push_back(cont_byte());
                  s.push_back(cont_byte());
               end
               default: s.push_back(8'($urandom_range(8'hC2, 8'hF4)));
            endcase
         end else if (kind < 80) begin
            repeat ($urandom_range(1, 3)) s.push_back(pick_space());
         end else if (kind < 84) begin
            c = 8'($urandom_range(0, 31));
            s.push_back((ws_byte(c) || c == CH_NUL) ? CH_DEL : c);
         end else if (kind < 91) begin
            s.push_back(shell_meta[$urandom_range(0, 22)]);
         end else if (kind < 93) begin
            s.push_back(CH_NUL);
         end else begin
            s.push_back(8'($urandom));
         end
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) s.push_back(pick_space());
      return s;
   endfunction

   task automatic run_random(int budget);
      int n;
      n = 0;
      while (n < budget) n += add_path(random_path(), $urandom_range(0, 7) == 0);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (byte_feed.size() != 0 || req_valid || pending_verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      reg_write_type w;
      w.index = idx;
      w.value = val;
      reg_writes.push_back(w);
      do @(negedge clock);
      while (reg_writes.size() != 0 || csr_valid);
   endtask

   task automatic configure(logic [CFG_LEN_WIDTH-1:0] max_len, logic strict, logic allow_rel);
      set_reg(REG_MAX_LENGTH, max_len);
      set_reg(REG_STRICT_MODE, {15'($urandom), strict});
      set_reg(REG_ALLOW_RELATIVE, {15'($urandom), allow_rel});
   endtask

   initial begin : sequencer
      byte_q_type bq;
      int n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      sender_idle_pct = 10;
      rsp_idle_pct    = 10;

      // reset configuration
      bq = {};
      n = add_path(bq, 1'b1);
      n = add_path(text_bytes("  /a  "), 1'b0);
      n = add_path(text_bytes("/.."), 1'b0);
      n = add_path(text_bytes("/%252E"), 1'b0);
      n = add_path(text_bytes("\t\n"), 1'b0);
      bq = {CH_SLASH, 8'h61, CH_NUL};
      n = add_path(bq, 1'b0);
      n = add_path(text_bytes("/a \nb"), 1'b0);
      bq = {CH_SLASH, 8'hC3, 8'hA9};
      n = add_path(bq, 1'b0);
      bq = {CH_SLASH, 8'hE0, 8'h9F, 8'h80};
      n = add_path(bq, 1'b0);
      bq = {CH_SLASH, 8'hF0};
      n = add_path(bq, 1'b1);
      bq = {CH_SLASH, 8'hF4, 8'h90, 8'h80, 8'h80};
      n = add_path(bq, 1'b0);
      bq = {CH_SLASH, 8'hC2, CH_SPACE, 8'h80};
      n = add_path(bq, 1'b0);
      n = add_path(text_bytes("a"), 1'b0);
      wait_drained();

      configure(16'hFFFF, 1'b1, 1'b0);
      n = add_path(text_bytes("/a;b"), 1'b0);
      n = add_path(text_bytes("rel"), 1'b0);
      n = add_path(text_bytes("/ok"), 1'b0);
      bq = {CH_SLASH, CH_DEL};
      n = add_path(bq, 1'b0);
      n = add_path(text_bytes("/%C0%AE"), 1'b0);
      run_random(150);
      wait_drained();

      configure(16'h0000, 1'b0, 1'b1);
      run_random(80);
      wait_drained();

      // long output hold-off while bytes keep coming
      sender_idle_pct = 0;
      rsp_idle_pct    = 8;
      configure(16'd8, 1'b1, 1'b1);
      run_random(250);
      hold_requests = hold_requests + 1;
      wait_drained();

      for (int r = 0; r < 3; r++) begin
         sender_idle_pct = (r == 1) ? 0 : 15;
         rsp_idle_pct    = (r == 2) ? 0 : 25;
         configure(16'($urandom_range(3, 40)), 1'($urandom), 1'($urandom));
         set_reg(REG_UNUSED, 16'($urandom));
         run_random(120);
         wait_drained();
      end

      // closing stretch without idling
      sender_idle_pct = 0;
      rsp_idle_pct    = 0;
      configure(16'd20, 1'b1, 1'b0);
      run_random(150);
      wait_drained();

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
